>>> rtl/core/cia_pkg.sv
package cia_pkg;

   localparam int unsigned DATA_W    = 64;
   localparam int unsigned NUM_STEPS = DATA_W;
   localparam int unsigned CNT_W     = $clog2(NUM_STEPS);

   localparam logic [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DOM   = 2'd1,
      ST_RANGE = 2'd2,
      ST_SKIP  = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic iter_next;
   } dp_sts_type;

endpackage

>>> rtl/core/cia_req_if.sv
interface cia_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic signed [63:0] element;
   logic signed [63:0] operand;
   logic        last_in;

   modport source (output valid, req_type, element, operand, last_in, input ready);
   modport sink   (input valid, req_type, element, operand, last_in, output ready);
endinterface

>>> rtl/core/cia_rsp_if.sv
interface cia_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [63:0] new_value;
   logic [1:0]  status;
   logic        last_out;

   modport source (output valid, new_value, status, last_out, input ready);
   modport sink   (input valid, new_value, status, last_out, output ready);
endinterface

>>> rtl/core/checked_int64_alu.sv
// checked_int64_alu: overflow-checked signed 64-bit add, subtract, multiply,
// divide and remainder applied to the elements of a run.
// req_bus carries one element, operand, operation code and last marker per
// beat; rsp_bus returns one beat with the new value, status and last marker.
// One item is processed at a time; req_bus.ready is high only while idle.
// Add, subtract, unused codes, skipped elements and divide errors found up
// front go from idle straight to the finish state, which registers the result.
// Multiply, divide and remainder run 64 steps of one shared shift-add /
// restoring-subtract unit in the calc state before the finish state; no new
// item is taken until the previous one has left the finish state.
// The response sits in an output register; while the sink stalls a new item
// is still taken and computed, and it waits in its final state until the
// output register frees up.
// After the first error in a run, the rest of that run comes back as
// skipped; the error flag clears after the beat marked last.
// Synchronous reset clears the controller, the pending response and the
// run error flag.
module checked_int64_alu
   import cia_pkg::*;
(
   input logic       clock,
   input logic       reset,
   cia_req_if.sink   req_bus,
   cia_rsp_if.source rsp_bus
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   cia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cia_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_type  (req_bus.req_type),
      .element   (req_bus.element),
      .operand   (req_bus.operand),
      .last_in   (req_bus.last_in),
      .new_value (rsp_bus.new_value),
      .status    (rsp_bus.status),
      .last_out  (rsp_bus.last_out)
   );

endmodule

>>> rtl/core/cia_datapath.sv
module cia_datapath
   import cia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_sts_type         sts,
   input  logic [2:0]         req_type,
   input  logic signed [63:0] element,
   input  logic signed [63:0] operand,
   input  logic               last_in,
   output logic signed [63:0] new_value,
   output logic [1:0]         status,
   output logic               last_out
);

   logic [DATA_W-1:0] x_u, y_u, ax, ay, add_r, sub_r;
   logic              xneg, yneg, add_ovf, sub_ovf, pre_iter;
   status_type        pre_status;
   logic [DATA_W-1:0] pre_value;

   logic              run_failed_ff, run_failed_in;
   op_type            op_ff;
   logic              last_ff, xneg_ff, sgn_diff_ff, iter_ff;
   status_type        pre_status_ff;
   logic [DATA_W-1:0] pre_value_ff, x_ff, mag_ff;
   logic [DATA_W-1:0] acc_hi_ff, acc_hi_in, acc_lo_ff, acc_lo_in;

   logic signed [63:0] new_value_ff;
   status_type         status_ff;
   logic               last_out_ff;

   assign x_u  = element;
   assign y_u  = operand;
   assign xneg = x_u[DATA_W-1];
   assign yneg = y_u[DATA_W-1];
   assign ax   = xneg ? (~x_u + 1'b1) : x_u;
   assign ay   = yneg ? (~y_u + 1'b1) : y_u;

   assign add_r   = x_u + y_u;
   assign sub_r   = x_u - y_u;
   assign add_ovf = ((x_u[DATA_W-1] ^ add_r[DATA_W-1]) & (y_u[DATA_W-1] ^ add_r[DATA_W-1]));
   assign sub_ovf = ((x_u[DATA_W-1] ^ y_u[DATA_W-1]) & (x_u[DATA_W-1] ^ sub_r[DATA_W-1]));

   // results that need no iteration are settled at accept time
   always_comb begin
      pre_status = ST_OK;
      pre_value  = x_u;
      pre_iter   = 1'b0;
      if (run_failed_ff) begin
         pre_status = ST_SKIP;
      end else begin
         case (op_type'(req_type)) inside
            OP_ADD: begin
               if (add_ovf) pre_status = ST_RANGE;
               else pre_value = add_r;
            end
            OP_SUB: begin
               if (sub_ovf) pre_status = ST_RANGE;
               else pre_value = sub_r;
            end
            OP_MUL: pre_iter = 1'b1;
            OP_DIV, OP_REM: begin
               if (y_u == '0) pre_status = ST_DOM;
               else if ((x_u == MIN_VALUE) && (&y_u)) pre_status = ST_RANGE;
               else pre_iter = 1'b1;
            end
            default: pre_iter = 1'b0;
         endcase
      end
   end

   assign sts.iter_next = pre_iter;

   // one shift-add or restore-subtract per step
   logic              is_mul;
   logic [DATA_W:0]   mul_sum, div_trial, div_diff;
   logic              div_ge;

   assign is_mul    = (op_ff == OP_MUL);
   assign mul_sum   = {1'b0, acc_hi_ff} + (acc_lo_ff[0] ? {1'b0, mag_ff} : '0);
   assign div_trial = {acc_hi_ff, acc_lo_ff[DATA_W-1]};
   assign div_diff  = div_trial - {1'b0, mag_ff};
   assign div_ge    = (div_trial >= {1'b0, mag_ff});

   always_comb begin
      acc_hi_in = acc_hi_ff;
      acc_lo_in = acc_lo_ff;
      if (cmd.load) begin
         acc_hi_in = '0;
         acc_lo_in = (op_type'(req_type) == OP_MUL) ? ay : ax;
      end else if (cmd.step) begin
         if (is_mul) begin
            acc_hi_in = mul_sum[DATA_W:1];
            acc_lo_in = {mul_sum[0], acc_lo_ff[DATA_W-1:1]};
         end else begin
            acc_hi_in = div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
            acc_lo_in = {acc_lo_ff[DATA_W-2:0], div_ge};
         end
      end
   end

   // final sign fix and checks
   logic              mul_ovf, neg_res;
   logic [DATA_W-1:0] mag_res, fin_val, out_val;
   status_type        fin_status;

   assign mul_ovf = (acc_hi_ff != '0) ||
                    (sgn_diff_ff ? (acc_lo_ff > MIN_VALUE) : (acc_lo_ff >= MIN_VALUE));
   assign mag_res = (op_ff == OP_REM) ? acc_hi_ff : acc_lo_ff;
   assign neg_res = (op_ff == OP_REM) ? xneg_ff : sgn_diff_ff;
   assign fin_val = neg_res ? (~mag_res + 1'b1) : mag_res;

   always_comb begin
      if (iter_ff) begin
         fin_status = (is_mul && mul_ovf) ? ST_RANGE : ST_OK;
         out_val    = (fin_status == ST_OK) ? fin_val : x_ff;
      end else begin
         fin_status = pre_status_ff;
         out_val    = pre_value_ff;
      end
   end

   assign run_failed_in = !last_ff &&
                          (run_failed_ff || (fin_status == ST_DOM) || (fin_status == ST_RANGE));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_failed_ff <= 1'b0;
      end else if (cmd.finish) begin
         run_failed_ff <= run_failed_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_hi_ff <= acc_hi_in;
      acc_lo_ff <= acc_lo_in;
      if (cmd.load) begin
         op_ff         <= op_type'(req_type);
         x_ff          <= x_u;
         xneg_ff       <= xneg;
         sgn_diff_ff   <= xneg ^ yneg;
         last_ff       <= last_in;
         iter_ff       <= pre_iter;
         pre_status_ff <= pre_status;
         pre_value_ff  <= pre_value;
         mag_ff        <= (op_type'(req_type) == OP_MUL) ? ax : ay;
      end
      if (cmd.finish) begin
         new_value_ff <= out_val;
         status_ff    <= fin_status;
         last_out_ff  <= last_ff;
      end
   end

   assign new_value = new_value_ff;
   assign status    = status_ff;
   assign last_out  = last_out_ff;

endmodule

>>> rtl/core/cia_ctrl.sv
module cia_ctrl
   import cia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CALC   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.iter_next ? S_CALC : S_FINISH;
            end
         end
         S_CALC: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register holds a beat until the sink takes it
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CALC) |-> (cnt_ff == '0))
      else $error("step counter not cleared outside calc");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result written over an unread beat");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ((state_ff == S_IDLE) && req_valid && !cmd.step && !cmd.finish))
      else $error("load outside idle");

   a_calc_len: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CALC) && (cnt_ff == CNT_W'(NUM_STEPS - 1))) |=> (state_ff == S_FINISH))
      else $error("calc did not end after last step");

endmodule

>>> verif/tb_checked_int64_alu.sv
`timescale 1ns / 100ps

module tb_checked_int64_alu;
   import cia_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam logic signed [63:0] MOST_NEG  = MIN_VALUE;
   localparam logic signed [63:0] MOST_POS  = ~MIN_VALUE;
   localparam logic signed [63:0] MINUS_ONE = -64'sd1;
   localparam logic signed [63:0] TWO_P32   = 64'sd4294967296;
   localparam logic signed [63:0] TWO_P31   = 64'sd2147483648;

   typedef struct {
      logic signed [63:0] value;
      status_type         status;
      logic               last;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset;

   cia_req_if req_bus ();
   cia_rsp_if rsp_bus ();

   checked_int64_alu uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   alu_result_type expected_results[$];
   alu_result_type oldest_result;
   logic        run_error_seen = 1'b0;
   logic        no_idle = 1'b0;
   int          fail_count = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          cycle_count = 0;
   int          ok_seen = 0;
   int          dom_seen = 0;
   int          range_seen = 0;
   int          skip_seen = 0;

   // expected result of one beat; advances the run error flag
   function automatic alu_result_type predict_result(logic [2:0] code, logic signed [63:0] x,
                                                     logic signed [63:0] y, logic last);
      alu_result_type     res;
      logic [127:0]       wide;
      logic signed [63:0] r;
      status_type         st;
      res.value = x;
      res.last  = last;
      if (run_error_seen) begin
         res.status = ST_SKIP;
      end else begin
         st = ST_OK;
         r  = x;
         case (code)
            OP_ADD: begin
               r = x + y;
               if (x[63] == y[63] && r[63] != x[63]) st = ST_RANGE;
            end
            OP_SUB: begin
               r = x - y;
               if (x[63] != y[63] && r[63] != x[63]) st = ST_RANGE;
            end
            OP_MUL: begin
               // low 128 bits of the product are the same signed or unsigned
               wide = {{64{x[63]}}, x} * {{64{y[63]}}, y};
               if (wide[127:63] != {65{wide[63]}}) st = ST_RANGE;
               else r = wide[63:0];
            end
            OP_DIV, OP_REM: begin
               if (y == 0) st = ST_DOM;
               else if (x == MOST_NEG && y == MINUS_ONE) st = ST_RANGE;
               else if (code == OP_DIV) r = x / y;
               else r = x % y;
            end
            default: ;
         endcase
         if (st == ST_OK) res.value = r;
         else run_error_seen = 1'b1;
         res.status = st;
      end
      if (last) run_error_seen = 1'b0;
      return res;
   endfunction

   function automatic logic signed [63:0] rand_operand();
      logic signed [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0, 1, 2: ;
         3, 4: v = v >>> $urandom_range(1, 62);
         5: v = $signed(64'($urandom_range(0, 40))) - 64'sd20;
         6: v = (v[0] ? MOST_NEG : MOST_POS) ^ 64'($urandom_range(0, 3));
         default: v = $signed(64'($urandom_range(0, 2))) - 64'sd1;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] rand_code();
      if ($urandom_range(0, 15) == 0) return 3'($urandom_range(OP_REM + 1, 7));
      return 3'($urandom_range(OP_ADD, OP_REM));
   endfunction

   task automatic send_item(logic [2:0] code, logic signed [63:0] x,
                            logic signed [63:0] y, logic last);
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 99) < 9) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= code;
      req_bus.element  <= x;
      req_bus.operand  <= y;
      req_bus.last_in  <= last;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_result(code, x, y, last));
      beats_in++;
   endtask

   task automatic req_go_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic test_edge_values();
      send_item(OP_ADD, MOST_POS, 64'sd1, 1'b1);
      send_item(OP_ADD, MOST_NEG, MINUS_ONE, 1'b1);
      send_item(OP_ADD, MOST_POS, MOST_NEG, 1'b1);
      send_item(OP_SUB, MOST_NEG, 64'sd1, 1'b1);
      send_item(OP_SUB, 64'sd0, MOST_NEG, 1'b1);
      send_item(OP_MUL, MOST_NEG, 64'sd1, 1'b1);
      send_item(OP_MUL, MOST_NEG, MINUS_ONE, 1'b1);
      send_item(OP_MUL, TWO_P32, TWO_P31, 1'b1);
      send_item(OP_MUL, -TWO_P32, TWO_P31, 1'b1);
      send_item(OP_MUL, MOST_POS, MOST_POS, 1'b1);
      send_item(OP_MUL, 64'sd0, MOST_NEG, 1'b1);
      send_item(OP_DIV, 64'sd7, 64'sd0, 1'b1);
      send_item(OP_DIV, MOST_NEG, MINUS_ONE, 1'b1);
      send_item(OP_DIV, -64'sd7, 64'sd2, 1'b1);
      send_item(OP_REM, MOST_NEG, MINUS_ONE, 1'b1);
      send_item(OP_REM, -64'sd7, 64'sd2, 1'b1);
   endtask

   task automatic test_unused_codes();
      send_item(3'(OP_REM + 1), MOST_NEG, 64'sd0, 1'b1);
      send_item(3'(OP_REM + 2), 64'sd12345, MINUS_ONE, 1'b1);
      send_item(3'(OP_REM + 3), MOST_POS, MOST_POS, 1'b1);
   endtask

   task automatic test_error_runs();
      // error mid-run, rest of the run skipped
      send_item(OP_ADD, 64'sd1, 64'sd2, 1'b0);
      send_item(OP_DIV, 64'sd5, 64'sd0, 1'b0);
      send_item(OP_MUL, 64'sd3, 64'sd4, 1'b0);
      send_item(OP_ADD, 64'sd1, 64'sd1, 1'b1);
      // error on the last beat, next run starts clean
      send_item(OP_ADD, MOST_POS, 64'sd1, 1'b1);
      send_item(OP_ADD, 64'sd1, 64'sd1, 1'b1);
   endtask

   task automatic test_random_runs(int count);
      int   sent;
      int   len;
      logic last;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len && sent < count; i++) begin
            last = (i == len - 1);
            // occasional broken run marker
            if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
            send_item(rand_code(), rand_operand(), rand_operand(), last);
            sent++;
         end
      end
   endtask

   task automatic test_drain_pause();
      repeat (5) begin
         test_random_runs(10);
         req_go_idle();
         while (expected_results.size() != 0) @(posedge clock);
      end
   endtask

   task automatic test_no_idle(int count);
      no_idle = 1'b1;
      test_random_runs(count);
      no_idle = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (no_idle || $urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_out++;
         case (rsp_bus.status)
            ST_OK:    ok_seen++;
            ST_DOM:   dom_seen++;
            ST_RANGE: range_seen++;
            ST_SKIP:  skip_seen++;
            default: ;
         endcase
         if (expected_results.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result beat %0d: value %0d status %0d last %0b",
                        beats_out, rsp_bus.new_value, rsp_bus.status, rsp_bus.last_out);
            fail_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_bus.new_value !== oldest_result.value ||
                rsp_bus.status !== oldest_result.status ||
                rsp_bus.last_out !== oldest_result.last) begin
               if (fail_count < 10)
                  $display("mismatch beat %0d: expected %0d/%s/%0b, got %0d/%0d/%0b",
                           beats_out, oldest_result.value, oldest_result.status.name(),
                           oldest_result.last, rsp_bus.new_value, rsp_bus.status,
                           rsp_bus.last_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("tb_checked_int64_alu: done, errors");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = '0;
      req_bus.element  = '0;
      req_bus.operand  = '0;
      req_bus.last_in  = 1'b0;
      rsp_bus.ready    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_values();
      test_unused_codes();
      test_error_runs();
      test_random_runs(450);
      test_drain_pause();
      test_no_idle(150);
      req_go_idle();

      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("sent %0d beats, checked %0d results in %0d cycles", beats_in, beats_out,
               cycle_count);
      $display("status mix: %0d ok, %0d divide by zero, %0d out of range, %0d skipped",
               ok_seen, dom_seen, range_seen, skip_seen);
      if (fail_count == 0) begin
         $display("tb_checked_int64_alu: done, clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("tb_checked_int64_alu: done, errors");
      end
      $finish;
   end

endmodule
